// ===== hdl/fde_pkg.sv =====
// ----------------------------------------------------------------------------
// fde_pkg
// Shared codes, types and tables for the FAT32 directory entry parser.
// ----------------------------------------------------------------------------
package fde_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Special byte values of a directory entry.
    localparam logic [7:0] BYTE_END   = 8'h00;
    localparam logic [7:0] BYTE_FREE  = 8'hE5;
    localparam logic [7:0] ATTR_LFN   = 8'h0F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    // Entry layout.
    localparam logic [4:0] POS_LAST     = 5'd31;
    localparam int         ATTR_OFFSET  = 11;
    localparam int         SHORT_NAME_N = 11;

    // Long-name characters per entry.
    localparam logic [7:0] LFN_CHARS = 8'd13;
    localparam logic [3:0] LFN_LAST  = 4'd12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take;          // store the accepted byte
        logic       restart;       // the accepted byte starts a new directory
        logic       setup;         // latch character emission parameters
        logic       setup_long;    // characters come from a long-name entry
        logic [3:0] setup_cnt_m1;  // sequence number of the long entry minus one
        logic       load;          // load one result into the output register
        logic [1:0] kind;
        logic       hl;            // had_long_name for a record
        logic       last;          // last_of_run for the loaded result
    } fde_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       at_last;       // the byte at hand is the last of an entry
        logic [7:0] first_byte;
        logic       attr_lfn;
        logic       name_empty;    // the 8.3 name is all spaces
        logic       out_free;      // the output register can take a result
        logic       char_last;     // the current character is the final one
    } fde_sts_t;

    // Entry offsets of the 13 long-name characters.
    function automatic logic [4:0] lfn_offset(input logic [3:0] k);
        logic [4:0] off;
        unique case (k)
            4'd0:    off = 5'd1;
            4'd1:    off = 5'd3;
            4'd2:    off = 5'd5;
            4'd3:    off = 5'd7;
            4'd4:    off = 5'd9;
            4'd5:    off = 5'd14;
            4'd6:    off = 5'd16;
            4'd7:    off = 5'd18;
            4'd8:    off = 5'd20;
            4'd9:    off = 5'd22;
            4'd10:   off = 5'd24;
            4'd11:   off = 5'd28;
            4'd12:   off = 5'd30;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== hdl/fde_datapath.sv =====
// ----------------------------------------------------------------------------
// fde_datapath
// Entry byte store, byte position, character sequencing and output register.
// ----------------------------------------------------------------------------
module fde_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           entry_byte,
    input  fde_pkg::fde_cmd_t    cmd,
    output fde_pkg::fde_sts_t    sts,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           result_kind,
    output logic [7:0]           name_index,
    output logic [7:0]           name_char,
    output logic [31:0]          file_size,
    output logic [31:0]          start_cluster,
    output logic                 had_long_name,
    output logic                 last_of_run
);

    logic [4:0]  pos_reg;
    logic [4:0]  pos_eff;
    logic [7:0]  store_reg [0:31];

    logic [3:0]  char_k_reg;
    logic        char_long_reg;
    logic [7:0]  char_base_reg;
    logic [3:0]  name_len_reg;
    logic [3:0]  name_len;
    logic [4:0]  rd_idx;
    logic        char_last;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  index_reg;
    logic [7:0]  char_reg;
    logic [31:0] size_reg;
    logic [31:0] cluster_reg;
    logic        hl_reg;
    logic        last_reg;
    logic        out_free;

    // A new directory puts the accepted byte at offset zero.
    assign pos_eff = cmd.restart ? 5'd0 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 5'd0;
        end
        else if (cmd.take)
        begin
            pos_reg <= pos_eff + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            store_reg[pos_eff] <= entry_byte;
        end
    end

    // Length of the 8.3 name once trailing spaces are dropped.
    always_comb
    begin
        name_len = 4'd0;
        for (int i = 0; i < fde_pkg::SHORT_NAME_N; i++)
        begin
            if (store_reg[i] != fde_pkg::BYTE_SPACE)
            begin
                name_len = 4'(i + 1);
            end
        end
    end

    assign char_last = char_long_reg ? (char_k_reg == fde_pkg::LFN_LAST)
                                     : (4'(char_k_reg + 4'd1) == name_len_reg);
    assign rd_idx    = char_long_reg ? fde_pkg::lfn_offset(char_k_reg)
                                     : {1'b0, char_k_reg};
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_k_reg    <= 4'd0;
            char_long_reg <= 1'b0;
            char_base_reg <= 8'd0;
            name_len_reg  <= 4'd0;
        end
        else if (cmd.setup)
        begin
            char_k_reg    <= 4'd0;
            char_long_reg <= cmd.setup_long;
            char_base_reg <= {4'd0, cmd.setup_cnt_m1} * fde_pkg::LFN_CHARS;
            name_len_reg  <= name_len;
        end
        else if (cmd.load && cmd.kind == fde_pkg::KIND_CHAR && !char_last)
        begin
            char_k_reg <= char_k_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= cmd.kind;
            hl_reg      <= 1'b0;
            last_reg    <= cmd.last;
            index_reg   <= 8'd0;
            char_reg    <= 8'd0;
            size_reg    <= 32'd0;
            cluster_reg <= 32'd0;
            unique case (cmd.kind)
                fde_pkg::KIND_CHAR:
                begin
                    index_reg <= char_long_reg ? char_base_reg + {4'd0, char_k_reg}
                                               : {4'd0, char_k_reg};
                    char_reg  <= store_reg[rd_idx];
                end
                fde_pkg::KIND_RECORD:
                begin
                    hl_reg      <= cmd.hl;
                    size_reg    <= {store_reg[31], store_reg[30],
                                    store_reg[29], store_reg[28]};
                    cluster_reg <= {store_reg[21], store_reg[20],
                                    store_reg[27], store_reg[26]};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sts.at_last    = (pos_eff == fde_pkg::POS_LAST);
    assign sts.first_byte = store_reg[0];
    assign sts.attr_lfn   = (store_reg[fde_pkg::ATTR_OFFSET] == fde_pkg::ATTR_LFN);
    assign sts.name_empty = (name_len == 4'd0);
    assign sts.out_free   = out_free;
    assign sts.char_last  = char_last;

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign name_index    = index_reg;
    assign name_char     = char_reg;
    assign file_size     = size_reg;
    assign start_cluster = cluster_reg;
    assign had_long_name = hl_reg;
    assign last_of_run   = last_reg;

    // The controller loads a result only when the output register is free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> out_free)
        else $error("result loaded into a full output register");

    // The character counter stays within one long-name entry.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_k_reg <= fde_pkg::LFN_LAST)
        else $error("character counter out of range");

    // A short-name character lies inside the trimmed name.
    a_short_in_name: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.kind == fde_pkg::KIND_CHAR && !char_long_reg)
        |-> (char_k_reg < name_len_reg))
        else $error("short-name character beyond the trimmed name");

endmodule

// ===== hdl/fde_ctrl.sv =====
// ----------------------------------------------------------------------------
// fde_ctrl
// Controller: judges each completed entry and sequences its results.
// ----------------------------------------------------------------------------
module fde_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 dir_start,
    input  fde_pkg::fde_sts_t    sts,
    output fde_pkg::fde_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_JUDGE  = 3'd1;
    localparam logic [2:0] S_CHARS  = 3'd2;
    localparam logic [2:0] S_RECORD = 3'd3;
    localparam logic [2:0] S_END    = 3'd4;

    logic [2:0] state_reg,   state_next;
    logic [3:0] left_reg,    left_next;
    logic       pending_reg, pending_next;
    logic       ended_reg,   ended_next;
    logic       long_reg,    long_next;
    logic       hl_reg,      hl_next;

    logic       accept;
    logic       ended_eff;
    logic [3:0] count;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign ended_eff = dir_start ? 1'b0 : ended_reg;
    assign count     = sts.first_byte[3:0];

    always_comb
    begin
        state_next   = state_reg;
        left_next    = left_reg;
        pending_next = pending_reg;
        ended_next   = ended_reg;
        long_next    = long_reg;
        hl_next      = hl_reg;

        cmd              = '0;
        cmd.restart      = accept && dir_start;
        cmd.take         = accept && !ended_eff;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.restart)
                begin
                    left_next    = 4'd0;
                    pending_next = 1'b0;
                    ended_next   = 1'b0;
                end
                if (cmd.take && sts.at_last)
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                // Entries inside an open run are taken without any checks.
                if (pending_reg)
                begin
                    if (left_reg != 4'd0)
                    begin
                        cmd.setup        = 1'b1;
                        cmd.setup_long   = 1'b1;
                        cmd.setup_cnt_m1 = left_reg - 4'd1;
                        left_next        = left_reg - 4'd1;
                        long_next        = 1'b1;
                        state_next       = S_CHARS;
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        hl_next      = 1'b1;
                        state_next   = S_RECORD;
                    end
                end
                else if (sts.first_byte == fde_pkg::BYTE_END)
                begin
                    ended_next = 1'b1;
                    state_next = S_END;
                end
                else if (sts.first_byte == fde_pkg::BYTE_FREE)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.attr_lfn)
                begin
                    // A run count of zero closes itself with a record.
                    if (count == 4'd0)
                    begin
                        hl_next    = 1'b1;
                        state_next = S_RECORD;
                    end
                    else
                    begin
                        cmd.setup        = 1'b1;
                        cmd.setup_long   = 1'b1;
                        cmd.setup_cnt_m1 = count - 4'd1;
                        left_next        = count - 4'd1;
                        pending_next     = 1'b1;
                        long_next        = 1'b1;
                        state_next       = S_CHARS;
                    end
                end
                else
                begin
                    hl_next = 1'b0;
                    if (sts.name_empty)
                    begin
                        state_next = S_RECORD;
                    end
                    else
                    begin
                        cmd.setup  = 1'b1;
                        long_next  = 1'b0;
                        state_next = S_CHARS;
                    end
                end
            end
            S_CHARS:
            begin
                cmd.load = sts.out_free;
                cmd.kind = fde_pkg::KIND_CHAR;
                cmd.last = sts.char_last && long_reg;
                if (sts.out_free && sts.char_last)
                begin
                    state_next = long_reg ? S_IDLE : S_RECORD;
                end
            end
            S_RECORD:
            begin
                cmd.load = sts.out_free;
                cmd.kind = fde_pkg::KIND_RECORD;
                cmd.hl   = hl_reg;
                cmd.last = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                cmd.load = sts.out_free;
                cmd.kind = fde_pkg::KIND_END;
                cmd.last = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            left_reg    <= 4'd0;
            pending_reg <= 1'b0;
            ended_reg   <= 1'b0;
            long_reg    <= 1'b0;
            hl_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            left_reg    <= left_next;
            pending_reg <= pending_next;
            ended_reg   <= ended_next;
            long_reg    <= long_next;
            hl_reg      <= hl_next;
        end
    end

    // The last byte of an entry is always followed by its judgment.
    a_judge: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && sts.at_last) |=> (state_reg == S_JUDGE))
        else $error("completed entry was not judged");

    // Remaining long entries exist only inside an open run.
    a_left_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != 4'd0) |-> pending_reg)
        else $error("long entries left without an open run");

    // After the end of the directory only the end marker is still to go.
    a_ended_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> (state_reg == S_IDLE || state_reg == S_END))
        else $error("activity after end of directory");

endmodule

// ===== hdl/fat32_directory_entry_parser.sv =====
// ----------------------------------------------------------------------------
// fat32_directory_entry_parser
// Gathers directory bytes into 32-byte entries and emits name characters,
// file records and an end-of-directory marker.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------------
//  input     in_valid / in_stall    entry_byte, dir_start
//  output    out_valid / out_stall  result_kind, name_index, name_char,
//                                   file_size, start_cluster,
//                                   had_long_name, last_of_run
//
//  A byte that does not complete an entry is taken without a stall.
//  After the 32nd byte of an entry the controller judges the entry and then
//  walks the stored entry one result at a time (up to 13 results), each
//  loaded when the output register is free; the input stalls until the
//  last result is loaded.
//  The next byte is taken while the last result still waits in the output
//  register. A stalled output holds the register and pauses the sequence.
//  Reset clears the byte position, run state and end-of-directory flag.
// ----------------------------------------------------------------------------
module fat32_directory_entry_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  entry_byte,
    input  logic        dir_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  name_index,
    output logic [7:0]  name_char,
    output logic [31:0] file_size,
    output logic [31:0] start_cluster,
    output logic        had_long_name,
    output logic        last_of_run
);

    fde_pkg::fde_cmd_t cmd;
    fde_pkg::fde_sts_t sts;

    fde_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dir_start (dir_start),
        .sts       (sts),
        .cmd       (cmd)
    );

    fde_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_byte    (entry_byte),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .name_index    (name_index),
        .name_char     (name_char),
        .file_size     (file_size),
        .start_cluster (start_cluster),
        .had_long_name (had_long_name),
        .last_of_run   (last_of_run)
    );

endmodule
